/* rtl/sfd_pkg.sv */
// Shared types and constants for the sample frame deframer.
// No dependencies; used by every module in rtl/.
package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = VALUE_W + 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'hEF;
    localparam logic [BYTE_W-1:0] COUNT_MAX     = 8'hFF;

    localparam logic [0:0] CFG_HEADER  = 1'b0;
    localparam logic [0:0] CFG_TRAILER = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_HIGH   = 5'b00100,
        PH_LOW    = 5'b01000,
        PH_END    = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic [BYTE_W-1:0]   index;
        logic [BYTE_W-1:0]   total;
    } result_t;

endpackage

/* rtl/sfd_parser.sv */
// Frame parser: configuration registers, phase state and result decode.
// Depends on sfd_pkg.
module sfd_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        in_accept,
    input  logic [sfd_pkg::BYTE_W-1:0]  in_byte,
    output logic                        res_valid,
    output sfd_pkg::result_t            res
);

    logic [sfd_pkg::BYTE_W-1:0] header_reg;
    logic [sfd_pkg::BYTE_W-1:0] trailer_reg;
    sfd_pkg::phase_t            phase_reg;
    sfd_pkg::phase_t            phase_next;
    logic [sfd_pkg::BYTE_W-1:0] expected_reg;
    logic [sfd_pkg::BYTE_W-1:0] expected_next;
    logic [sfd_pkg::BYTE_W-1:0] count_reg;
    logic [sfd_pkg::BYTE_W-1:0] count_next;
    logic [sfd_pkg::BYTE_W-1:0] high_reg;
    logic [sfd_pkg::BYTE_W-1:0] high_next;

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        high_next     = high_reg;
        res_valid     = 1'b0;
        res.kind      = sfd_pkg::KIND_SAMPLE;
        res.value     = '0;
        res.index     = '0;
        res.total     = '0;
        case (phase_reg)
            sfd_pkg::PH_LENGTH:
            begin
                expected_next = in_byte;
                count_next    = '0;
                phase_next    = sfd_pkg::PH_HIGH;
            end
            sfd_pkg::PH_HIGH:
            begin
                high_next  = in_byte;
                phase_next = sfd_pkg::PH_LOW;
            end
            sfd_pkg::PH_LOW:
            begin
                res_valid = 1'b1;
                res.value = {high_reg, in_byte};
                res.index = count_reg;
                if (count_reg != sfd_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                phase_next = (count_next >= expected_reg) ? sfd_pkg::PH_END
                                                          : sfd_pkg::PH_HIGH;
            end
            sfd_pkg::PH_END:
            begin
                res_valid  = 1'b1;
                res.kind   = (in_byte == trailer_reg) ? sfd_pkg::KIND_ACCEPT
                                                      : sfd_pkg::KIND_REJECT;
                res.total  = count_reg;
                phase_next = sfd_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = (in_byte == header_reg) ? sfd_pkg::PH_LENGTH
                                                     : sfd_pkg::PH_IDLE;
            end
        endcase
        res_valid = res_valid & in_accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= sfd_pkg::HEADER_RESET;
            trailer_reg  <= sfd_pkg::TRAILER_RESET;
            phase_reg    <= sfd_pkg::PH_IDLE;
            expected_reg <= '0;
            count_reg    <= '0;
            high_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sfd_pkg::CFG_HEADER:  header_reg  <= cfg_data;
                    sfd_pkg::CFG_TRAILER: trailer_reg <= cfg_data;
                    default:              header_reg  <= header_reg;
                endcase
            end
            if (in_accept)
            begin
                phase_reg    <= phase_next;
                expected_reg <= expected_next;
                count_reg    <= count_next;
                high_reg     <= high_next;
            end
        end
    end

endmodule

/* rtl/sfd_out_stage.sv */
// Result register with a skid entry for the master-side stream.
// Depends on sfd_pkg.
module sfd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfd_pkg::result_t push_data,
    output logic             room,
    output logic             out_valid,
    output sfd_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             out_valid_reg;
    sfd_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    sfd_pkg::result_t skid_data_reg;
    logic             out_load;

    assign out_load  = !out_valid_reg || out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

/* rtl/sample_frame_deframer.sv */
// Top level of the sample frame deframer: byte stream in, sample/result stream out.
// Depends on sfd_pkg, sfd_parser and sfd_out_stage.
//
// Takes one received byte per cycle while input is ready. A byte equal to the
// header register opens a frame, the next byte gives the sample count (zero counts
// as one), byte pairs follow high byte first, and one trailer byte closes the
// frame. Each sample is delivered as it completes; the trailer byte yields an
// accept or reject result with the sample total. Each result is registered in the
// output stage. The byte rate is one per cycle, set by the single parser state
// update; a two-entry output register keeps input ready while one result waits,
// so input stalls only when the output side has held back two results.
module sample_frame_deframer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sfd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sfd_pkg::TDATA_W-1:0]  m_tdata,   // [15:0] sample_value,
                                                    // [23:16] sample_index,
                                                    // [31:24] frame_samples
    output logic [sfd_pkg::KIND_W-1:0]   m_tuser    // [1:0] result_kind
);

    logic             in_accept;
    logic             res_valid;
    sfd_pkg::result_t res;
    sfd_pkg::result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    sfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.total, out_res.index, out_res.value};
    assign m_tuser = out_res.kind;

endmodule

/* tb/sv/tb_sfd_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the sample frame deframer testbench: byte-level frame parser
// prediction and an in-order check of the result stream. Depends on sfd_pkg.
package tb_sfd_scoreboard_pkg;

    class deframer_scoreboard;

        logic [sfd_pkg::BYTE_W-1:0] header_reg;
        logic [sfd_pkg::BYTE_W-1:0] trailer_reg;
        sfd_pkg::phase_t            phase;
        logic [sfd_pkg::BYTE_W-1:0] count_target;
        logic [sfd_pkg::BYTE_W-1:0] samples_seen;
        logic [sfd_pkg::BYTE_W-1:0] high_part;
        sfd_pkg::result_t           pending_results [$];
        int                         failures;

        function new();
            header_reg   = sfd_pkg::HEADER_RESET;
            trailer_reg  = sfd_pkg::TRAILER_RESET;
            phase        = sfd_pkg::PH_IDLE;
            count_target = '0;
            samples_seen = '0;
            high_part    = '0;
            failures     = 0;
        endfunction

        function void write_register(logic [0:0] index,
                                     logic [sfd_pkg::BYTE_W-1:0] value);
            if (index == sfd_pkg::CFG_HEADER)
                header_reg = value;
            else
                trailer_reg = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the parser by one accepted byte and queue what it yields.
        function void take_byte(logic [sfd_pkg::BYTE_W-1:0] rx);
            sfd_pkg::result_t r;
            case (phase)
                sfd_pkg::PH_LENGTH:
                begin
                    count_target = rx;
                    samples_seen = '0;
                    phase        = sfd_pkg::PH_HIGH;
                end
                sfd_pkg::PH_HIGH:
                begin
                    high_part = rx;
                    phase     = sfd_pkg::PH_LOW;
                end
                sfd_pkg::PH_LOW:
                begin
                    r.kind  = sfd_pkg::KIND_SAMPLE;
                    r.value = {high_part, rx};
                    r.index = samples_seen;
                    r.total = '0;
                    pending_results.push_back(r);
                    if (samples_seen < sfd_pkg::COUNT_MAX)
                        samples_seen = samples_seen + 1'b1;
                    phase = (samples_seen >= count_target) ? sfd_pkg::PH_END
                                                           : sfd_pkg::PH_HIGH;
                end
                sfd_pkg::PH_END:
                begin
                    r.kind  = (rx == trailer_reg) ? sfd_pkg::KIND_ACCEPT
                                                  : sfd_pkg::KIND_REJECT;
                    r.value = '0;
                    r.index = '0;
                    r.total = samples_seen;
                    pending_results.push_back(r);
                    phase = sfd_pkg::PH_IDLE;
                end
                default:
                begin
                    phase = (rx == header_reg) ? sfd_pkg::PH_LENGTH
                                               : sfd_pkg::PH_IDLE;
                end
            endcase
        endfunction

        function void check_result(logic [sfd_pkg::KIND_W-1:0] kind,
                                   logic [sfd_pkg::TDATA_W-1:0] data);
            sfd_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result kind=%0d data=%h", kind, data);
                return;
            end
            want = pending_results.pop_front();
            if (kind != want.kind || data[15:0] != want.value
                || data[23:16] != want.index || data[31:24] != want.total)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: exp kind/value/index/total %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                             want.kind, want.value, want.index, want.total,
                             kind, data[15:0], data[23:16], data[31:24]);
            end
        endfunction

    endclass

endpackage

/* tb/sv/tb_sample_frame_deframer.sv */
`timescale 1ns / 100ps
// Top testbench for sample_frame_deframer: directed and random byte streams
// over several register settings and idle patterns. Depends on sfd_pkg,
// tb_sfd_scoreboard_pkg and the RTL top level.
module tb_sample_frame_deframer;

    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_BYTES  = 125;
    localparam int SETTLE_TICKS = 6;

    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_RECV   = 2;
    localparam int MODE_BOTH   = 3;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [0:0]                  cfg_index;
    logic [sfd_pkg::BYTE_W-1:0]  cfg_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [sfd_pkg::BYTE_W-1:0]  s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [sfd_pkg::TDATA_W-1:0] m_tdata;
    logic [sfd_pkg::KIND_W-1:0]  m_tuser;

    tb_sfd_scoreboard_pkg::deframer_scoreboard sb;
    int                          idle_mode;
    int                          quiet_cycles;
    int                          phase_bytes;
    logic [sfd_pkg::BYTE_W-1:0]  cur_header;
    logic [sfd_pkg::BYTE_W-1:0]  cur_trailer;

    sample_frame_deframer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            MODE_SENDER: return $urandom_range(0, 99) < 72;
            MODE_BOTH:   return $urandom_range(0, 99) < 35;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            MODE_RECV: return $urandom_range(0, 99) < 72;
            MODE_BOTH: return $urandom_range(0, 99) < 35;
            default:   return 1'b0;
        endcase
    endfunction

    // Hold the byte until the request is taken.
    task automatic send_byte(logic [sfd_pkg::BYTE_W-1:0] rx);
        @(negedge clk);
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_byte(rx);
        phase_bytes++;
    endtask

    task automatic send_frame(int unsigned count, bit good_trailer);
        int unsigned n;
        send_byte(cur_header);
        send_byte(count[7:0]);
        n = (count == 0) ? 1 : count;
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
        if (good_trailer)
            send_byte(cur_trailer);
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] index, logic [sfd_pkg::BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Check each result taken from the stream and track inactivity.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                    sb.check_result(m_tuser, m_tdata);
                if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !receiver_stalls();
        end
    end

    initial
    begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [sfd_pkg::BYTE_W-1:0] directed_bytes [];
        int unsigned count;

        directed_bytes = '{
            8'hAA, 8'h00, 8'hFF, 8'hFF, 8'hEF,
            8'hAA, 8'h01, 8'hAA, 8'h00, 8'hAA,
            8'h5A, 8'hAA, 8'h02, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00,
            8'hAA, 8'h00, 8'h01, 8'h80, 8'hEF
        };
        sb          = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = sfd_pkg::CFG_HEADER;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_mode   = MODE_NONE;
        cur_header  = sfd_pkg::HEADER_RESET;
        cur_trailer = sfd_pkg::TRAILER_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                case (p)
                    1:
                    begin
                        cur_header  = 8'h00;
                        cur_trailer = 8'hFF;
                    end
                    2:
                    begin
                        cur_header  = 8'hFF;
                        cur_trailer = 8'h00;
                    end
                    4:
                    begin
                        cur_header  = sfd_pkg::HEADER_RESET;
                        cur_trailer = sfd_pkg::TRAILER_RESET;
                    end
                    5:
                    begin
                        cur_header  = 8'($urandom_range(0, 255));
                        cur_trailer = cur_header;
                    end
                    default:
                    begin
                        cur_header  = 8'($urandom_range(0, 255));
                        cur_trailer = 8'($urandom_range(0, 255));
                    end
                endcase
                write_register(sfd_pkg::CFG_HEADER, cur_header);
                write_register(sfd_pkg::CFG_TRAILER, cur_trailer);
            end
            idle_mode   = p % 4;
            phase_bytes = 0;

            if (p == 0)
                foreach (directed_bytes[i])
                    send_byte(directed_bytes[i]);
            if (p == 6)
                send_frame(255, 1'b1);

            while (phase_bytes < PHASE_BYTES)
            begin
                if ($urandom_range(0, 99) < 20)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                count = $urandom_range(0, 99);
                if (count < 90)
                    count = $urandom_range(0, 6);
                else
                    count = $urandom_range(7, 40);
                send_frame(count, $urandom_range(0, 99) < 75);
            end
        end

        drain_results();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
